FILE: sv/ghr_pkg.sv
// ----------------------------------------------------------------------------
// ghr_pkg
// Shared types, codes and helpers for the generational handle registry.
// ----------------------------------------------------------------------------
package ghr_pkg;

  localparam int CMD_W      = 3;
  localparam int KEY_PORT_W = 64;
  localparam int HIDX_W     = 9;
  localparam int GEN_W      = 16;
  localparam int STAT_W     = 3;
  localparam int HITS_W     = 32;

  typedef logic [GEN_W-1:0] gen_t;

  // command codes
  localparam logic [CMD_W-1:0] CMD_FIND      = 3'd0;
  localparam logic [CMD_W-1:0] CMD_FIND_ALLOC = 3'd1;
  localparam logic [CMD_W-1:0] CMD_REG_WORLD = 3'd2;
  localparam logic [CMD_W-1:0] CMD_RESOLVE   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_FREE      = 3'd4;

  // result status codes
  localparam logic [STAT_W-1:0] ST_FOUND    = 3'd0;
  localparam logic [STAT_W-1:0] ST_ALLOC    = 3'd1;
  localparam logic [STAT_W-1:0] ST_NOTFOUND = 3'd2;
  localparam logic [STAT_W-1:0] ST_FULL     = 3'd3;
  localparam logic [STAT_W-1:0] ST_INVALID  = 3'd4;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_READ,
    S_HCHK,
    S_DONE
  } state_t;

  // status from the scan unit to the sequencer
  typedef struct packed {
    logic done;
    logic found;
    logic free_found;
  } scan_flags_t;

  // generation advance, zero is kept for the null handle
  function automatic gen_t next_gen(gen_t g);
    gen_t n;
    n = g + gen_t'(1);
    return (n == '0) ? gen_t'(1) : n;
  endfunction

endpackage

FILE: sv/ghr_if.sv
// ----------------------------------------------------------------------------
// ghr_if
// Command and result channel interfaces of the handle registry.
// ----------------------------------------------------------------------------
interface ghr_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  command;
  logic [63:0] key;
  logic [8:0]  handle_index;
  logic [15:0] handle_generation;

  modport source (
    output valid, command, key, handle_index, handle_generation,
    input  ready
  );
  modport sink (
    input  valid, command, key, handle_index, handle_generation,
    output ready
  );
endinterface

interface ghr_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [8:0]  out_index;
  logic [15:0] out_generation;
  logic [31:0] hit_count;

  modport source (
    output valid, status, out_index, out_generation, hit_count,
    input  ready
  );
  modport sink (
    input  valid, status, out_index, out_generation, hit_count,
    output ready
  );
endinterface

FILE: sv/ghr_slot_mem.sv
// ----------------------------------------------------------------------------
// ghr_slot_mem
// Slot table storage: one write port, one registered read port.
// ----------------------------------------------------------------------------
module ghr_slot_mem #(
  parameter int DEPTH = 512,
  parameter int WIDTH = 81
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: sv/ghr_scan_unit.sv
// ----------------------------------------------------------------------------
// ghr_scan_unit
// Walks slots 0..extent-1 one a cycle: first key match and first free slot.
// ----------------------------------------------------------------------------
module ghr_scan_unit #(
  parameter int MAX_SLOTS = 512,
  parameter int KEY_BITS  = 64
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [KEY_BITS-1:0]            key,
  input  logic [$clog2(MAX_SLOTS+1)-1:0] extent,
  input  logic                           world_ok,
  input  logic                           rd_used,
  input  ghr_pkg::gen_t                  rd_gen,
  input  logic [KEY_BITS-1:0]            rd_key,
  output logic [$clog2(MAX_SLOTS)-1:0]   rd_addr,
  output ghr_pkg::scan_flags_t           flags,
  output logic [$clog2(MAX_SLOTS)-1:0]   found_idx,
  output ghr_pkg::gen_t                  found_gen,
  output logic [$clog2(MAX_SLOTS)-1:0]   free_idx,
  output ghr_pkg::gen_t                  free_gen
);
  import ghr_pkg::*;

  localparam int IDX_W = $clog2(MAX_SLOTS);
  localparam int EXT_W = $clog2(MAX_SLOTS+1);

  logic             busy_r, busy_nxt;
  logic [EXT_W-1:0] issue_r, issue_nxt;
  logic             chk_v_r, chk_v_nxt;
  logic [IDX_W-1:0] chk_idx_r, chk_idx_nxt;
  logic             done_r, done_nxt;
  logic             found_r, found_nxt;
  logic [IDX_W-1:0] found_idx_r, found_idx_nxt;
  gen_t             found_gen_r, found_gen_nxt;
  logic             free_v_r, free_v_nxt;
  logic [IDX_W-1:0] free_idx_r, free_idx_nxt;
  gen_t             free_gen_r, free_gen_nxt;

  logic used_now, hit_now, free_now, issue_go;

  // slot 0 reads as empty until the world entry is written
  assign used_now = rd_used && ((chk_idx_r != '0) || world_ok);
  assign hit_now  = busy_r && chk_v_r && used_now && (rd_key == key);
  assign free_now = busy_r && chk_v_r && !used_now && (chk_idx_r != '0) && !free_v_r;
  assign issue_go = busy_r && !hit_now && (issue_r < extent);
  assign rd_addr  = issue_r[IDX_W-1:0];

  always_comb begin
    busy_nxt      = busy_r;
    issue_nxt     = issue_r;
    chk_v_nxt     = 1'b0;
    chk_idx_nxt   = chk_idx_r;
    done_nxt      = 1'b0;
    found_nxt     = found_r;
    found_idx_nxt = found_idx_r;
    found_gen_nxt = found_gen_r;
    free_v_nxt    = free_v_r;
    free_idx_nxt  = free_idx_r;
    free_gen_nxt  = free_gen_r;
    if (start) begin
      busy_nxt   = 1'b1;
      issue_nxt  = '0;
      found_nxt  = 1'b0;
      free_v_nxt = 1'b0;
    end else if (busy_r) begin
      if (issue_go) begin
        issue_nxt   = issue_r + EXT_W'(1);
        chk_v_nxt   = 1'b1;
        chk_idx_nxt = issue_r[IDX_W-1:0];
      end
      if (free_now) begin
        free_v_nxt   = 1'b1;
        free_idx_nxt = chk_idx_r;
        free_gen_nxt = rd_gen;
      end
      if (hit_now) begin
        found_nxt     = 1'b1;
        found_idx_nxt = chk_idx_r;
        found_gen_nxt = rd_gen;
        busy_nxt      = 1'b0;
        done_nxt      = 1'b1;
      end else if (!chk_v_r && (issue_r >= extent)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      chk_v_r <= 1'b0;
      done_r  <= 1'b0;
    end else begin
      busy_r  <= busy_nxt;
      chk_v_r <= chk_v_nxt;
      done_r  <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    issue_r     <= issue_nxt;
    chk_idx_r   <= chk_idx_nxt;
    found_r     <= found_nxt;
    found_idx_r <= found_idx_nxt;
    found_gen_r <= found_gen_nxt;
    free_v_r    <= free_v_nxt;
    free_idx_r  <= free_idx_nxt;
    free_gen_r  <= free_gen_nxt;
  end

  assign flags.done       = done_r;
  assign flags.found      = found_r;
  assign flags.free_found = free_v_r;
  assign found_idx        = found_idx_r;
  assign found_gen        = found_gen_r;
  assign free_idx         = free_idx_r;
  assign free_gen         = free_gen_r;

endmodule

FILE: sv/generational_handle_registry_unit.sv
// ----------------------------------------------------------------------------
// generational_handle_registry_unit
// Slot table handing out generation-checked handles, with a pinned world slot.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake     | payload
//  in_ch    | in  | valid / ready | command, key, handle_index, handle_generation
//  out_ch   | out | valid / ready | status, out_index, out_generation, hit_count
//
//  find and find-or-allocate step through slots 0..extent-1 one a cycle over
//  the slot memory's single read port and stop early on a match; world
//  registration, resolve and free read one slot and then check or write it,
//  unknown codes skip to the result stage; idle follows the output load.
//  in_ch.ready is high only while idle; one item is in flight at a time and a
//  result waits in the output register until taken. No clearing pass after
//  reset: slots at or above the extent count read as empty, slot 0 has a flag.
// ----------------------------------------------------------------------------
module generational_handle_registry_unit #(
  parameter int MAX_SLOTS = 512,
  parameter int KEY_BITS  = 64
) (
  input  logic             clk,
  input  logic             rst_n,
  ghr_req_if.sink          in_ch,
  ghr_rsp_if.source        out_ch
);
  import ghr_pkg::*;

  localparam int IDX_W = $clog2(MAX_SLOTS);
  localparam int EXT_W = $clog2(MAX_SLOTS+1);
  localparam int ENT_W = 1 + GEN_W + KEY_BITS;
  localparam int CMP_W = (EXT_W > HIDX_W) ? EXT_W : HIDX_W;

  state_t state_r, state_nxt;

  logic [CMD_W-1:0]    cmd_r;
  logic [KEY_BITS-1:0] key_r;
  logic [HIDX_W-1:0]   hidx_r;
  gen_t                hgen_r;

  logic [EXT_W-1:0]  extent_r, extent_nxt;
  logic [HITS_W-1:0] hits_r, hits_nxt;
  logic              world_ok_r, world_ok_nxt;

  logic [STAT_W-1:0] res_status_r, res_status_nxt;
  logic [HIDX_W-1:0] res_idx_r, res_idx_nxt;
  gen_t              res_gen_r, res_gen_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [STAT_W-1:0] out_status_r;
  logic [HIDX_W-1:0] out_idx_r;
  gen_t              out_gen_r;
  logic [HITS_W-1:0] out_hits_r;
  logic              out_load;

  logic              in_acc;
  logic              mem_we;
  logic [IDX_W-1:0]  mem_waddr, mem_raddr;
  logic [ENT_W-1:0]  mem_wdata, mem_rdata;
  logic              rd_used;
  gen_t              rd_gen;
  logic [KEY_BITS-1:0] rd_key;

  logic                scan_start;
  logic [IDX_W-1:0]    scan_addr;
  scan_flags_t         scan_flags;
  logic [IDX_W-1:0]    found_idx, free_idx;
  gen_t                found_gen, free_gen;

  logic h_ok, h_used;
  gen_t g_new;

  assign in_acc      = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE);

  assign rd_used = mem_rdata[ENT_W-1];
  assign rd_gen  = mem_rdata[ENT_W-2 -: GEN_W];
  assign rd_key  = mem_rdata[KEY_BITS-1:0];

  ghr_slot_mem #(
    .DEPTH (MAX_SLOTS),
    .WIDTH (ENT_W)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  ghr_scan_unit #(
    .MAX_SLOTS (MAX_SLOTS),
    .KEY_BITS  (KEY_BITS)
  ) u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (scan_start),
    .key       (key_r),
    .extent    (extent_r),
    .world_ok  (world_ok_r),
    .rd_used   (rd_used),
    .rd_gen    (rd_gen),
    .rd_key    (rd_key),
    .rd_addr   (scan_addr),
    .flags     (scan_flags),
    .found_idx (found_idx),
    .found_gen (found_gen),
    .free_idx  (free_idx),
    .free_gen  (free_gen)
  );

  // handle check against the slot read in the previous cycle
  assign h_used = rd_used && ((hidx_r != '0) || world_ok_r);
  assign h_ok   = (hgen_r != '0) && (CMP_W'(hidx_r) < CMP_W'(extent_r))
                  && h_used && (rd_gen == hgen_r);
  assign g_new  = next_gen(world_ok_r ? rd_gen : gen_t'(0));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    scan_start     = 1'b0;
    mem_we         = 1'b0;
    mem_waddr      = '0;
    mem_wdata      = '0;
    mem_raddr      = scan_addr;
    extent_nxt     = extent_r;
    hits_nxt       = hits_r;
    world_ok_nxt   = world_ok_r;
    res_status_nxt = res_status_r;
    res_idx_nxt    = res_idx_r;
    res_gen_nxt    = res_gen_r;
    out_load       = 1'b0;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          case (in_ch.command)
            CMD_FIND, CMD_FIND_ALLOC: begin
              scan_start = 1'b1;
              state_nxt  = S_SCAN;
            end
            CMD_REG_WORLD, CMD_RESOLVE, CMD_FREE: begin
              state_nxt = S_READ;
            end
            default: begin
              res_status_nxt = ST_NOTFOUND;
              res_idx_nxt    = '0;
              res_gen_nxt    = '0;
              state_nxt      = S_DONE;
            end
          endcase
        end
      end
      S_SCAN: begin
        if (scan_flags.done) begin
          state_nxt = S_DONE;
          if (scan_flags.found) begin
            res_status_nxt = ST_FOUND;
            res_idx_nxt    = HIDX_W'(found_idx);
            res_gen_nxt    = found_gen;
            if (cmd_r == CMD_FIND_ALLOC) begin
              hits_nxt = hits_r + HITS_W'(1);
            end
          end else if (cmd_r != CMD_FIND_ALLOC) begin
            res_status_nxt = ST_NOTFOUND;
            res_idx_nxt    = '0;
            res_gen_nxt    = '0;
          end else if (scan_flags.free_found) begin
            mem_we         = 1'b1;
            mem_waddr      = free_idx;
            mem_wdata      = {1'b1, next_gen(free_gen), key_r};
            res_status_nxt = ST_ALLOC;
            res_idx_nxt    = HIDX_W'(free_idx);
            res_gen_nxt    = next_gen(free_gen);
          end else if (extent_r < EXT_W'(MAX_SLOTS)) begin
            // grow: the new slot was never touched, so its generation is zero
            mem_we         = 1'b1;
            mem_waddr      = extent_r[IDX_W-1:0];
            mem_wdata      = {1'b1, next_gen(gen_t'(0)), key_r};
            extent_nxt     = extent_r + EXT_W'(1);
            res_status_nxt = ST_ALLOC;
            res_idx_nxt    = HIDX_W'(extent_r[IDX_W-1:0]);
            res_gen_nxt    = next_gen(gen_t'(0));
          end else begin
            res_status_nxt = ST_FULL;
            res_idx_nxt    = '0;
            res_gen_nxt    = '0;
          end
        end
      end
      S_READ: begin
        mem_raddr = (cmd_r == CMD_REG_WORLD) ? IDX_W'(0) : IDX_W'(hidx_r);
        state_nxt = S_HCHK;
      end
      S_HCHK: begin
        state_nxt = S_DONE;
        if (cmd_r == CMD_REG_WORLD) begin
          mem_we         = 1'b1;
          mem_waddr      = '0;
          mem_wdata      = {1'b1, g_new, key_r};
          world_ok_nxt   = 1'b1;
          res_status_nxt = ST_ALLOC;
          res_idx_nxt    = '0;
          res_gen_nxt    = g_new;
        end else if (!h_ok) begin
          res_status_nxt = ST_INVALID;
          res_idx_nxt    = '0;
          res_gen_nxt    = '0;
        end else if (cmd_r == CMD_FREE) begin
          mem_we         = 1'b1;
          mem_waddr      = IDX_W'(hidx_r);
          mem_wdata      = {1'b0, next_gen(rd_gen), rd_key};
          res_status_nxt = ST_FOUND;
          res_idx_nxt    = hidx_r;
          res_gen_nxt    = '0;
        end else begin
          res_status_nxt = ST_FOUND;
          res_idx_nxt    = hidx_r;
          res_gen_nxt    = hgen_r;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_load      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      extent_r    <= EXT_W'(1);
      hits_r      <= '0;
      world_ok_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      extent_r    <= extent_nxt;
      hits_r      <= hits_nxt;
      world_ok_r  <= world_ok_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      cmd_r  <= in_ch.command;
      key_r  <= in_ch.key[KEY_BITS-1:0];
      hidx_r <= in_ch.handle_index;
      hgen_r <= in_ch.handle_generation;
    end
    res_status_r <= res_status_nxt;
    res_idx_r    <= res_idx_nxt;
    res_gen_r    <= res_gen_nxt;
    if (out_load) begin
      out_status_r <= res_status_r;
      out_idx_r    <= res_idx_r;
      out_gen_r    <= res_gen_r;
      out_hits_r   <= hits_r;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.status         = out_status_r;
  assign out_ch.out_index      = out_idx_r;
  assign out_ch.out_generation = out_gen_r;
  assign out_ch.hit_count      = out_hits_r;

`ifndef ASSERT_OFF
  a_extent_range: assert property (@(posedge clk) disable iff (!rst_n)
    (extent_r != '0) && (extent_r <= EXT_W'(MAX_SLOTS)))
    else $error("slot extent out of range");

  a_write_state: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == S_SCAN || state_r == S_HCHK))
    else $error("slot write outside a command step");

  a_scan_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    scan_flags.done |-> (state_r == S_SCAN))
    else $error("scan finished while not scanning");

  a_alloc_gen: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r == ST_ALLOC) |-> (out_gen_r != '0))
    else $error("allocated handle carries null generation");

  a_extent_grow: assert property (@(posedge clk) disable iff (!rst_n)
    (extent_r != $past(extent_r)) |-> (extent_r == $past(extent_r) + EXT_W'(1)))
    else $error("extent moved by other than one");
`endif

endmodule
